### rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, suspended while rst is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion sampled on clk, checked during reset too.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/mtx_pkg.sv
// ----------------------------------------------------------------------------
// mtx_pkg
// Types, constants and the tempering function of the keystream XOR cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtx_pkg;

  localparam int MT_N = 624;
  localparam int MT_M = 397;
  localparam int AW   = $clog2(MT_N);

  localparam logic [31:0] MT_MATRIX    = 32'h9908_B0DF;
  localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;
  localparam logic [31:0] SEED_RESET   = 32'd5489;

  localparam logic [AW-1:0] LAST_IDX = AW'(MT_N - 1);

  // Register indexes of the configuration port.
  localparam logic REG_SEED = 1'b0;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SEED = 6'b000010,
    ST_RDA  = 6'b000100,
    ST_RDB  = 6'b001000,
    ST_RDC  = 6'b010000,
    ST_WR   = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    ADDR_K  = 2'd0,
    ADDR_K1 = 2'd1,
    ADDR_KM = 2'd2
  } addr_sel_t;

  typedef struct packed {
    logic      item_load;
    logic      seed_step;
    addr_sel_t rd_sel;
    logic      cap_hi;
    logic      cap_lo;
    logic      twist_wr;
  } cmd_t;

  typedef struct packed {
    logic seed_last;
    logic out_busy;
  } status_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

### rtl/core/mtx_ctrl.sv
// ----------------------------------------------------------------------------
// mtx_ctrl
// Sequencer: item accept, reseed sweep, three state reads and one write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtx_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic            s_tuser,
  input  wire mtx_pkg::status_t status,
  output mtx_pkg::cmd_t        cmd
);

  mtx_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtx_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    cmd.item_load = 1'b0;
    cmd.seed_step = 1'b0;
    cmd.rd_sel    = mtx_pkg::ADDR_K;
    cmd.cap_hi    = 1'b0;
    cmd.cap_lo    = 1'b0;
    cmd.twist_wr  = 1'b0;
    case (state)
      mtx_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.item_load = 1'b1;
          state_next    = s_tuser ? mtx_pkg::ST_SEED : mtx_pkg::ST_RDA;
        end
      end
      mtx_pkg::ST_SEED: begin
        cmd.seed_step = 1'b1;
        if (status.seed_last) begin
          state_next = mtx_pkg::ST_RDA;
        end
      end
      mtx_pkg::ST_RDA: begin
        cmd.rd_sel = mtx_pkg::ADDR_K;
        state_next = mtx_pkg::ST_RDB;
      end
      mtx_pkg::ST_RDB: begin
        cmd.rd_sel = mtx_pkg::ADDR_K1;
        cmd.cap_hi = 1'b1;
        state_next = mtx_pkg::ST_RDC;
      end
      mtx_pkg::ST_RDC: begin
        cmd.rd_sel = mtx_pkg::ADDR_KM;
        cmd.cap_lo = 1'b1;
        state_next = mtx_pkg::ST_WR;
      end
      mtx_pkg::ST_WR: begin
        // hold the read address so the third word stays valid while stalled
        cmd.rd_sel = mtx_pkg::ADDR_KM;
        if (!status.out_busy) begin
          cmd.twist_wr = 1'b1;
          state_next   = mtx_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mtx_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/mtx_dp.sv
// ----------------------------------------------------------------------------
// mtx_dp
// Datapath: generator state memory, seed sweep, per-word twist, tempering
// and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtx_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mtx_pkg::cmd_t cmd,
  output mtx_pkg::status_t   status,
  input  wire logic [31:0]   seed,
  input  wire logic [7:0]    in_data,
  input  wire logic          in_last,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last
);

  logic [31:0] mem [mtx_pkg::MT_N];
  logic [31:0] rd_data;
  logic [mtx_pkg::AW-1:0] rd_addr;
  logic [mtx_pkg::AW-1:0] wr_addr;
  logic [31:0] wr_data;
  logic        wr_en;

  logic [mtx_pkg::AW-1:0] k;
  logic [mtx_pkg::AW-1:0] k1;
  logic [mtx_pkg::AW-1:0] km;
  logic [mtx_pkg::AW:0]   km_sum;
  logic [mtx_pkg::AW-1:0] seed_cnt;
  logic [31:0] prev_word;
  logic [31:0] seed_word;
  logic        hi_bit;
  logic [30:0] lo_bits;
  logic [31:0] mix;
  logic [31:0] twist_word;
  logic [31:0] key;
  logic [7:0]  item_data;
  logic        item_last;

  // neighbor addresses, wrapped around the state
  always_comb begin
    k1     = (k == mtx_pkg::LAST_IDX) ? '0 : k + 1'b1;
    km_sum = {1'b0, k} + (mtx_pkg::AW+1)'(mtx_pkg::MT_M);
    if (km_sum >= (mtx_pkg::AW+1)'(mtx_pkg::MT_N)) begin
      km = mtx_pkg::AW'(km_sum - (mtx_pkg::AW+1)'(mtx_pkg::MT_N));
    end else begin
      km = km_sum[mtx_pkg::AW-1:0];
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      mtx_pkg::ADDR_K:  rd_addr = k;
      mtx_pkg::ADDR_K1: rd_addr = k1;
      mtx_pkg::ADDR_KM: rd_addr = km;
      default:          rd_addr = k;
    endcase
  end

  always_comb begin
    seed_word = mtx_pkg::MT_INIT_MULT * (prev_word ^ (prev_word >> 30))
                + {{(32-mtx_pkg::AW){1'b0}}, seed_cnt};
    if (seed_cnt == '0) begin
      seed_word = seed;
    end
    mix        = {hi_bit, lo_bits};
    twist_word = rd_data ^ (mix >> 1) ^ (mix[0] ? mtx_pkg::MT_MATRIX : 32'h0);
    key        = mtx_pkg::temper(twist_word);
  end

  always_comb begin
    wr_en   = cmd.seed_step | cmd.twist_wr;
    wr_addr = cmd.seed_step ? seed_cnt : k;
    wr_data = cmd.seed_step ? seed_word : twist_word;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign status.seed_last = (seed_cnt == mtx_pkg::LAST_IDX);
  assign status.out_busy  = out_valid & ~out_ready;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      seed_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.item_load) begin
        seed_cnt <= '0;
      end else if (cmd.seed_step) begin
        seed_cnt <= seed_cnt + 1'b1;
      end
      // restart the word pointer on reseed, advance after each twist
      if (cmd.seed_step) begin
        k <= '0;
      end else if (cmd.twist_wr) begin
        k <= k1;
      end
      if (cmd.twist_wr) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_data <= in_data;
      item_last <= in_last;
    end
    if (cmd.seed_step) begin
      prev_word <= seed_word;
    end
    if (cmd.cap_hi) begin
      hi_bit <= rd_data[31];
    end
    if (cmd.cap_lo) begin
      lo_bits <= rd_data[30:0];
    end
    if (cmd.twist_wr) begin
      out_byte <= item_data ^ key[7:0];
      out_last <= item_last;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mt19937_keystream_xor_cipher.sv
// ----------------------------------------------------------------------------
// mt19937_keystream_xor_cipher
// Byte stream cipher: each byte is XORed with the low byte of the next
// tempered MT19937 word; a start flag reseeds from the seed register.
// ----------------------------------------------------------------------------
// An item without the start flag runs an accept step, three reads of the
// 624-word state memory through its one read port (words k, k+1 and
// k+397) and a step that writes the twisted word back and loads the output
// register. An item with the start flag first runs a reseed sweep over all
// 624 state words, one state word per cycle through the initialization
// multiplier. The result register decouples the output side; a new item
// is taken while a result still waits.
// The first item after reset must carry the start flag. The seed register
// sits at byte address 0 of the configuration port and resets to 5489.
`timescale 1ns / 1ps
`default_nettype none

module mt19937_keystream_xor_cipher (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] start_of_message
  input  wire logic        s_tlast,
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_byte
  output logic             m_tlast
);

  logic [31:0]      seed;
  mtx_pkg::cmd_t    cmd;
  mtx_pkg::status_t status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mtx_pkg::REG_SEED) ? seed : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= mtx_pkg::SEED_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == mtx_pkg::REG_SEED) begin
      seed <= pwdata;
    end
  end

  mtx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  mtx_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .seed      (seed),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire

### rtl/core/mtx_checker.sv
// ----------------------------------------------------------------------------
// mtx_checker
// Port-level checks of the keystream cipher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mtx_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       pready,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       s_tuser,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // a stalled result holds
  `ASSERT_CLK_RST(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "stalled result changed")

  // one item at a time: busy right after a transaction
  `ASSERT_CLK_RST(a_busy_after_accept, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "input accepted while busy")

  // an item without reseed, taken while no result waits, gives its result after its reads and write
  `ASSERT_CLK_RST(a_result_latency, clk, rst, (s_tvalid && s_tready && !s_tuser && !m_tvalid) |-> ##5 m_tvalid, "result missing after item")

  // no result straight out of reset
  `ASSERT_CLK(a_reset_empty, clk, $past(rst) |-> !m_tvalid, "result valid after reset")

  `ASSERT_CLK(a_pready_high, clk, pready, "pready dropped")

endmodule

bind mt19937_keystream_xor_cipher mtx_checker u_mtx_checker (
  .clk      (clk),
  .rst      (rst),
  .pready   (pready),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

### bench/tb_mt19937_keystream_xor_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mt19937_keystream_xor_cipher
// Self-checking bench for the MT19937 keystream XOR cipher. A behavioral
// generator predicts every output byte from each accepted input transaction;
// a monitor compares the output stream in order. The run covers directed
// bytes and flag combinations, extreme seeds, random message traffic under
// several stall patterns and a long run that crosses a second twist.
// ----------------------------------------------------------------------------
module tb_mt19937_keystream_xor_cipher;

  localparam int          KEY_WORDS    = 624;
  localparam int          TWIST_SHIFT  = 397;
  localparam logic [31:0] TWIST_XOR    = 32'h9908_B0DF;
  localparam logic [31:0] SEED_MULT    = 32'd1812433253;
  localparam logic [31:0] SEED_DEFAULT = 32'd5489;
  localparam logic [2:0]  SEED_ADDR    = 3'd0;
  localparam int          CYCLE_LIMIT  = 5_000_000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } cipher_out_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] data_byte
  logic        s_tuser  = 1'b0; // [0] start_of_message
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [7:0] out_byte
  logic        m_tlast;

  int          tx_idle_pct = 7;
  int          rx_idle_pct = 87;
  int          err_count   = 0;
  int          cycle_count = 0;

  // Expected cipher outputs, oldest first
  cipher_out_t cipher_q[$];

  // Behavioral generator state
  logic [31:0] key_state [KEY_WORDS];
  int          key_pos    = KEY_WORDS;
  logic [31:0] seed_value = SEED_DEFAULT;

  mt19937_keystream_xor_cipher u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // ---- generator model ----

  function automatic void reseed_keystream(input logic [31:0] s);
    key_state[0] = s;
    for (int i = 1; i < KEY_WORDS; i++)
      key_state[i] = SEED_MULT * (key_state[i-1] ^ (key_state[i-1] >> 30)) + 32'(i);
    key_pos = KEY_WORDS;
  endfunction

  function automatic void twist_keystream();
    logic [31:0] y;
    logic [31:0] v;
    for (int i = 0; i < KEY_WORDS; i++) begin
      y = {key_state[i][31], key_state[(i + 1) % KEY_WORDS][30:0]};
      v = key_state[(i + TWIST_SHIFT) % KEY_WORDS] ^ (y >> 1);
      if (y[0]) v = v ^ TWIST_XOR;
      key_state[i] = v;
    end
    key_pos = 0;
  endfunction

  function automatic logic [7:0] next_key_byte();
    logic [31:0] y;
    if (key_pos >= KEY_WORDS) twist_keystream();
    y = key_state[key_pos];
    key_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y[7:0];
  endfunction

  function automatic void predict_cipher(input logic [7:0] d, input logic sof,
                                         input logic eof);
    cipher_out_t r;
    if (sof) reseed_keystream(seed_value);
    r.out_byte = d ^ next_key_byte();
    r.out_last = eof;
    cipher_q.push_back(r);
  endfunction

  // ---- output monitor ----

  always @(posedge clk) begin
    cipher_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual byte %h last %b",
                 $time, m_tdata, m_tlast);
        err_count++;
      end else begin
        want = cipher_q.pop_front();
        if (m_tdata !== want.out_byte) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, m_tdata);
          err_count++;
        end
        if (m_tlast !== want.out_last) begin
          $display("%0t: out_last expected %b actual %b", $time, want.out_last, m_tlast);
          err_count++;
        end
      end
    end
  end

  // ---- drivers ----

  task automatic send_byte(input logic [7:0] d, input logic sof, input logic eof);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= sof;
    s_tlast  <= eof;
    do @(posedge clk); while (!s_tready);
    predict_cipher(d, sof, eof);
  endtask

  // Hold the input side until every expected transaction has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEED_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seed_value = value;
  endtask

  // Noise adds stray start and end flags inside the message
  task automatic send_message(input int len, input bit reseed, input bit noise);
    logic sof;
    logic eof;
    for (int i = 0; i < len; i++) begin
      sof = (i == 0 && reseed) || (noise && $urandom_range(99) < 3);
      eof = (i == len - 1) || (noise && $urandom_range(99) < 4);
      send_byte(8'($urandom_range(255)), sof, eof);
    end
  endtask

  // ---- tests ----

  task automatic test_directed_bytes();
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h7E, 1'b0, 1'b1);
    // keystream continues past an end marker when no start follows
    send_byte(8'h3C, 1'b0, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b1);
    // single-byte message
    send_byte(8'hA5, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
  endtask

  task automatic test_seed_extremes();
    write_seed(32'h0000_0000);
    send_message(6, 1'b1, 1'b0);
    write_seed(32'hFFFF_FFFF);
    send_message(6, 1'b1, 1'b0);
  endtask

  task automatic test_random_messages(input int tx_pct, input int rx_pct,
                                      input int n_items, input bit pause_mid);
    int sent;
    int len;
    bit paused;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent   = 0;
    paused = 1'b0;
    write_seed($urandom);
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 20);
      send_message(len, $urandom_range(3) != 0, 1'b1);
      sent += len;
      if (pause_mid && !paused && sent >= n_items / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  // Run far enough past one reseed that a second twist is needed
  task automatic test_twist_boundary();
    int sent;
    int len;
    write_seed($urandom);
    send_message(40, 1'b1, 1'b0);
    sent = 40;
    while (sent < 630) begin
      len = $urandom_range(10, 60);
      send_message(len, 1'b0, 1'b0);
      sent += len;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_bytes();
    test_seed_extremes();
    test_random_messages(7, 87, 30, 1'b1);
    test_random_messages(87, 7, 30, 1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_twist_boundary();
    test_random_messages(0, 0, 30, 1'b0);
    wait_drained();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
